/* hw/rtl/aml_s5_pkg.sv */
// shared types, byte codes and helpers for the s5 sleep-type scanner
package aml_s5_pkg;

    // aml byte codes looked for in the table
    localparam logic [7:0] NAME_OP     = 8'h08;
    localparam logic [7:0] PACKAGE_OP  = 8'h12;
    localparam logic [7:0] BYTE_CONST  = 8'h0A;
    localparam logic [7:0] WORD_CONST  = 8'h0B;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_FIVE   = 8'h35;
    localparam logic [7:0] MIN_ELEMS   = 8'h02;

    // stream widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OUT_DATA_W = 2 * BYTE_W;

    // scan phase
    typedef enum logic [3:0] {
        PH_SEARCH  = 4'd0,
        PH_UNDER1  = 4'd1,
        PH_S       = 4'd2,
        PH_FIVE    = 4'd3,
        PH_UNDER2  = 4'd4,
        PH_PKGOP   = 4'd5,
        PH_PKGLEAD = 4'd6,
        PH_PKGSKIP = 4'd7,
        PH_COUNT   = 4'd8,
        PH_ELEM    = 4'd9,
        PH_BYTEVAL = 4'd10,
        PH_WORDLO  = 4'd11,
        PH_WORDHI  = 4'd12,
        PH_DONE    = 4'd13
    } t_phase;

    // one result of the scan
    typedef struct packed {
        logic                found;
        logic [BYTE_W-1:0]   sleep_type_a;
        logic [BYTE_W-1:0]   sleep_type_b;
    } t_s5_result;

    // a broken match restarts, a name opcode counts as a new start
    function automatic t_phase restart_phase(input logic [BYTE_W-1:0] b);
        restart_phase = (b == NAME_OP) ? PH_UNDER1 : PH_SEARCH;
    endfunction

endpackage

/* hw/rtl/aml_s5_scan.sv */
// byte-wise scan state machine that decodes the _S5_ package elements
module aml_s5_scan (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_take,
    input  logic [aml_s5_pkg::BYTE_W-1:0]        i_byte,
    input  logic                                 i_last,
    output logic                                 o_res_valid,
    output aml_s5_pkg::t_s5_result               o_res
);

    aml_s5_pkg::t_phase                  r_phase, n_phase;
    logic [1:0]                          r_skip, n_skip;
    logic                                r_idx, n_idx;
    logic [aml_s5_pkg::BYTE_W-1:0]       r_first, n_first;
    logic                                r_reported, n_reported;

    logic                                elem_take;
    logic                                elem_ok;

    // element value decode for the current byte
    always_comb begin
        elem_take = 1'b0;
        unique case (r_phase)
            aml_s5_pkg::PH_ELEM: begin
                elem_take = (i_byte != aml_s5_pkg::BYTE_CONST) &&
                            (i_byte != aml_s5_pkg::WORD_CONST);
            end
            aml_s5_pkg::PH_BYTEVAL: begin
                elem_take = 1'b1;
            end
            aml_s5_pkg::PH_WORDLO: begin
                // second word value needs its high byte to still be in the table
                elem_take = r_idx && !i_last;
            end
            default: begin
                elem_take = 1'b0;
            end
        endcase
        elem_ok = elem_take && r_idx;
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_skip     = r_skip;
        n_idx      = r_idx;
        n_first    = r_first;
        n_reported = r_reported;

        unique case (r_phase)
            aml_s5_pkg::PH_SEARCH: begin
                n_phase = aml_s5_pkg::restart_phase(i_byte);
            end
            aml_s5_pkg::PH_UNDER1: begin
                n_phase = (i_byte == aml_s5_pkg::CHAR_UNDER) ? aml_s5_pkg::PH_S
                        : aml_s5_pkg::restart_phase(i_byte);
            end
            aml_s5_pkg::PH_S: begin
                n_phase = (i_byte == aml_s5_pkg::CHAR_S) ? aml_s5_pkg::PH_FIVE
                        : aml_s5_pkg::restart_phase(i_byte);
            end
            aml_s5_pkg::PH_FIVE: begin
                n_phase = (i_byte == aml_s5_pkg::CHAR_FIVE) ? aml_s5_pkg::PH_UNDER2
                        : aml_s5_pkg::restart_phase(i_byte);
            end
            aml_s5_pkg::PH_UNDER2: begin
                n_phase = (i_byte == aml_s5_pkg::CHAR_UNDER) ? aml_s5_pkg::PH_PKGOP
                        : aml_s5_pkg::restart_phase(i_byte);
            end
            aml_s5_pkg::PH_PKGOP: begin
                n_phase = (i_byte == aml_s5_pkg::PACKAGE_OP) ? aml_s5_pkg::PH_PKGLEAD
                        : aml_s5_pkg::restart_phase(i_byte);
            end
            aml_s5_pkg::PH_PKGLEAD: begin
                // top two bits give the count of extra length bytes
                n_skip  = i_byte[7:6];
                n_phase = (i_byte[7:6] == 2'd0) ? aml_s5_pkg::PH_COUNT
                        : aml_s5_pkg::PH_PKGSKIP;
            end
            aml_s5_pkg::PH_PKGSKIP: begin
                n_skip = r_skip - 2'd1;
                if (r_skip == 2'd1) begin
                    n_phase = aml_s5_pkg::PH_COUNT;
                end
            end
            aml_s5_pkg::PH_COUNT: begin
                if (i_byte < aml_s5_pkg::MIN_ELEMS) begin
                    n_phase = aml_s5_pkg::PH_SEARCH;
                end else begin
                    n_idx   = 1'b0;
                    n_phase = aml_s5_pkg::PH_ELEM;
                end
            end
            aml_s5_pkg::PH_ELEM: begin
                if (i_byte == aml_s5_pkg::BYTE_CONST) begin
                    n_phase = aml_s5_pkg::PH_BYTEVAL;
                end else if (i_byte == aml_s5_pkg::WORD_CONST) begin
                    n_phase = aml_s5_pkg::PH_WORDLO;
                end
            end
            aml_s5_pkg::PH_WORDLO: begin
                if (!r_idx) begin
                    n_first = i_byte;
                    n_idx   = 1'b1;
                    n_phase = aml_s5_pkg::PH_WORDHI;
                end else if (i_last) begin
                    n_phase = aml_s5_pkg::PH_SEARCH;
                end
            end
            aml_s5_pkg::PH_WORDHI: begin
                n_phase = aml_s5_pkg::PH_ELEM;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // first element value captured, go for the second
        if (elem_take && !r_idx) begin
            n_first = i_byte;
            n_idx   = 1'b1;
            n_phase = aml_s5_pkg::PH_ELEM;
        end

        // both values decoded, ignore the rest of the table
        if (elem_ok) begin
            n_reported = 1'b1;
            n_phase    = aml_s5_pkg::PH_DONE;
        end

        // end of table returns everything to the start
        if (i_last) begin
            n_phase    = aml_s5_pkg::PH_SEARCH;
            n_skip     = 2'd0;
            n_idx      = 1'b0;
            n_first    = '0;
            n_reported = 1'b0;
        end
    end

    // result for the current byte
    always_comb begin
        o_res_valid        = i_take && (elem_ok || (i_last && !r_reported));
        o_res.found        = elem_ok;
        o_res.sleep_type_a = elem_ok ? r_first : '0;
        o_res.sleep_type_b = elem_ok ? i_byte  : '0;
    end

    // state registers, updated once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= aml_s5_pkg::PH_SEARCH;
            r_skip     <= 2'd0;
            r_idx      <= 1'b0;
            r_first    <= '0;
            r_reported <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_skip     <= n_skip;
            r_idx      <= n_idx;
            r_first    <= n_first;
            r_reported <= n_reported;
        end
    end

endmodule

/* hw/rtl/aml_s5_sleep_type_scanner_unit.sv */
// top level of the s5 sleep-type scanner: stream ports and result register
//
//  channel  | dir | tdata                      | tuser  | tlast
//  s_axis   | in  | [7:0] table_byte           | -      | last_byte
//  m_axis   | out | [7:0] sleep_type_a,        | found  | -
//           |     | [15:8] sleep_type_b        |        |
//
// one table byte is decided per cycle by the scan state machine; a byte can
// be taken every clock while the result register is empty or being drained.
// a result shows on the master side the cycle after the byte that caused it.
// the master side stalls the slave side only while a result waits untaken.
// synchronous active-low reset returns the scan to the search for a name opcode.
module aml_s5_sleep_type_scanner_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side: [7:0] table_byte
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [aml_s5_pkg::BYTE_W-1:0]         i_s_axis_tdata,
    input  logic                                  i_s_axis_tlast,
    // master side: [7:0] sleep_type_a, [15:8] sleep_type_b
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [aml_s5_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // master side user: [0] found
    output logic                                  o_m_axis_tuser
);

    logic                         s_take;
    logic                         scan_valid;
    aml_s5_pkg::t_s5_result       scan_res;

    logic                         r_out_valid;
    aml_s5_pkg::t_s5_result       r_out;

    // accept while the result register is free or drains this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;

    aml_s5_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (s_take),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_res_valid (scan_valid),
        .o_res       (scan_res)
    );

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= scan_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (scan_valid && o_s_axis_tready) begin
            r_out <= scan_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.sleep_type_b, r_out.sleep_type_a};
    assign o_m_axis_tuser  = r_out.found;

endmodule

/* sim/aml_s5_sleep_type_scanner_unit_tb.sv */
// testbench for the s5 sleep-type scanner: random tables, scan predictor and result checks
module aml_s5_sleep_type_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int TARGET_BYTES = 1150;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 400;
    localparam int TIMEOUT_NS   = 2_000_000;

    // scan predictor and store of expected scan results
    class t_s5_scoreboard;
        aml_s5_pkg::t_phase     scan_phase;
        logic [1:0]             skip_left;
        logic                   elem_sel;
        logic [7:0]             first_val;
        logic                   reported_flag;
        aml_s5_pkg::t_s5_result expected_q[$];
        int                     n_errors;
        int                     n_checked;
        int                     n_found;

        function new();
            clear_scan();
            n_errors  = 0;
            n_checked = 0;
            n_found   = 0;
        endfunction

        function void clear_scan();
            scan_phase    = aml_s5_pkg::PH_SEARCH;
            skip_left     = '0;
            elem_sel      = 1'b0;
            first_val     = '0;
            reported_flag = 1'b0;
        endfunction

        // a byte that breaks a match may itself open a new one
        function aml_s5_pkg::t_phase after_break(input logic [7:0] b);
            return (b == aml_s5_pkg::NAME_OP) ? aml_s5_pkg::PH_UNDER1
                                              : aml_s5_pkg::PH_SEARCH;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // advance the scan by one accepted byte and queue any result it causes
        function void note_byte(input logic [7:0] b, input logic last);
            logic                   take;
            logic                   decoded;
            logic [7:0]             val;
            aml_s5_pkg::t_s5_result res;
            take    = 1'b0;
            decoded = 1'b0;
            val     = '0;
            case (scan_phase)
                aml_s5_pkg::PH_SEARCH:  scan_phase = after_break(b);
                aml_s5_pkg::PH_UNDER1:
                    scan_phase = (b == aml_s5_pkg::CHAR_UNDER) ? aml_s5_pkg::PH_S
                                                               : after_break(b);
                aml_s5_pkg::PH_S:
                    scan_phase = (b == aml_s5_pkg::CHAR_S) ? aml_s5_pkg::PH_FIVE
                                                           : after_break(b);
                aml_s5_pkg::PH_FIVE:
                    scan_phase = (b == aml_s5_pkg::CHAR_FIVE) ? aml_s5_pkg::PH_UNDER2
                                                              : after_break(b);
                aml_s5_pkg::PH_UNDER2:
                    scan_phase = (b == aml_s5_pkg::CHAR_UNDER) ? aml_s5_pkg::PH_PKGOP
                                                               : after_break(b);
                aml_s5_pkg::PH_PKGOP:
                    scan_phase = (b == aml_s5_pkg::PACKAGE_OP) ? aml_s5_pkg::PH_PKGLEAD
                                                               : after_break(b);
                aml_s5_pkg::PH_PKGLEAD: begin
                    skip_left  = b[7:6];
                    scan_phase = (b[7:6] == 2'd0) ? aml_s5_pkg::PH_COUNT
                                                  : aml_s5_pkg::PH_PKGSKIP;
                end
                aml_s5_pkg::PH_PKGSKIP: begin
                    skip_left = skip_left - 2'd1;
                    if (skip_left == 2'd0) scan_phase = aml_s5_pkg::PH_COUNT;
                end
                aml_s5_pkg::PH_COUNT: begin
                    if (b < aml_s5_pkg::MIN_ELEMS) begin
                        scan_phase = aml_s5_pkg::PH_SEARCH;
                    end else begin
                        elem_sel   = 1'b0;
                        scan_phase = aml_s5_pkg::PH_ELEM;
                    end
                end
                aml_s5_pkg::PH_ELEM: begin
                    if (b == aml_s5_pkg::BYTE_CONST) scan_phase = aml_s5_pkg::PH_BYTEVAL;
                    else if (b == aml_s5_pkg::WORD_CONST) scan_phase = aml_s5_pkg::PH_WORDLO;
                    else begin
                        take = 1'b1;
                        val  = b;
                    end
                end
                aml_s5_pkg::PH_BYTEVAL: begin
                    take = 1'b1;
                    val  = b;
                end
                aml_s5_pkg::PH_WORDLO: begin
                    if (!elem_sel) begin
                        first_val  = b;
                        elem_sel   = 1'b1;
                        scan_phase = aml_s5_pkg::PH_WORDHI;
                    end else if (!last) begin
                        take = 1'b1;
                        val  = b;
                    end else begin
                        // high byte of the word is cut off by the table end
                        scan_phase = aml_s5_pkg::PH_SEARCH;
                    end
                end
                aml_s5_pkg::PH_WORDHI:  scan_phase = aml_s5_pkg::PH_ELEM;
                default: ;
            endcase

            if (take) begin
                if (!elem_sel) begin
                    first_val  = val;
                    elem_sel   = 1'b1;
                    scan_phase = aml_s5_pkg::PH_ELEM;
                end else begin
                    decoded = 1'b1;
                end
            end

            if (decoded) begin
                res.found        = 1'b1;
                res.sleep_type_a = first_val;
                res.sleep_type_b = val;
                expected_q.push_back(res);
                reported_flag = 1'b1;
                scan_phase    = aml_s5_pkg::PH_DONE;
            end

            // table end: report a failed search, then start over
            if (last) begin
                if (!decoded && !reported_flag) begin
                    res = '0;
                    expected_q.push_back(res);
                end
                clear_scan();
            end
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            n_errors++;
        endtask

        // compare one transfer from the master side with the oldest expectation
        task check_result(input aml_s5_pkg::t_s5_result got);
            aml_s5_pkg::t_s5_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b a=%02h b=%02h",
                    got.found, got.sleep_type_a, got.sleep_type_b));
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (want.found) n_found++;
                if (got.found !== want.found)
                    report_mismatch($sformatf("found %0b, expected %0b",
                        got.found, want.found));
                if (got.sleep_type_a !== want.sleep_type_a)
                    report_mismatch($sformatf("sleep_type_a %02h, expected %02h",
                        got.sleep_type_a, want.sleep_type_a));
                if (got.sleep_type_b !== want.sleep_type_b)
                    report_mismatch($sformatf("sleep_type_b %02h, expected %02h",
                        got.sleep_type_b, want.sleep_type_b));
            end
        endtask
    endclass

    logic                              i_clk           = 1'b0;
    logic                              i_rst_n         = 1'b0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [aml_s5_pkg::BYTE_W-1:0]     i_s_axis_tdata  = '0;     // [7:0] table_byte
    logic                              i_s_axis_tlast  = 1'b0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    // [7:0] sleep_type_a, [15:8] sleep_type_b
    logic [aml_s5_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                              o_m_axis_tuser;           // [0] found

    t_s5_scoreboard sb;
    logic [7:0]     table_q[$];
    int             n_tables = 0;
    int             n_bytes  = 0;
    logic           sender_quiet = 1'b0;

    aml_s5_sleep_type_scanner_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random byte leaning toward the codes the scanner reacts to
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return aml_s5_pkg::NAME_OP;
            1: return aml_s5_pkg::CHAR_UNDER;
            2: return aml_s5_pkg::PACKAGE_OP;
            default: return 8'($urandom);
        endcase
    endfunction

    // one package element: byte const, word const or a plain value
    function automatic void push_element(input int kind);
        logic [7:0] v;
        case (kind)
            0: begin
                table_q.push_back(aml_s5_pkg::BYTE_CONST);
                table_q.push_back(8'($urandom));
            end
            1: begin
                table_q.push_back(aml_s5_pkg::WORD_CONST);
                table_q.push_back(8'($urandom));
                table_q.push_back(8'($urandom));
            end
            default: begin
                do v = 8'($urandom);
                while (v == aml_s5_pkg::BYTE_CONST || v == aml_s5_pkg::WORD_CONST);
                table_q.push_back(v);
            end
        endcase
    endfunction

    function automatic void push_header(input int n);
        logic [7:0] hdr[6];
        hdr = '{aml_s5_pkg::NAME_OP, aml_s5_pkg::CHAR_UNDER, aml_s5_pkg::CHAR_S,
                aml_s5_pkg::CHAR_FIVE, aml_s5_pkg::CHAR_UNDER, aml_s5_pkg::PACKAGE_OP};
        for (int i = 0; i < n; i++) table_q.push_back(hdr[i]);
    endfunction

    // build the next random table into table_q
    function automatic void build_table();
        int         mode;
        int         keep;
        logic       cut_word;
        logic [7:0] lead;
        table_q.delete();
        mode = $urandom_range(0, 9);
        if (mode <= 5) begin
            // s5 package with random content, now and then damaged or cut short
            cut_word = ($urandom_range(0, 9) == 0);
            repeat ($urandom_range(0, 4)) table_q.push_back(noise_byte());
            push_header(6);
            lead = 8'($urandom);
            table_q.push_back(lead);
            repeat (lead[7:6]) table_q.push_back(8'($urandom));
            if ($urandom_range(0, 7) == 0) table_q.push_back(8'($urandom_range(0, 1)));
            else if ($urandom_range(0, 3) == 0) table_q.push_back(8'($urandom_range(2, 255)));
            else table_q.push_back(8'($urandom_range(2, 7)));
            push_element($urandom_range(0, 2));
            if (cut_word) begin
                // second element a word whose high byte is cut by the table end
                push_element(1);
                void'(table_q.pop_back());
            end else begin
                push_element($urandom_range(0, 2));
                repeat ($urandom_range(0, 3)) table_q.push_back(noise_byte());
                if ($urandom_range(0, 5) == 0)
                    table_q[$urandom_range(0, table_q.size() - 1)] = noise_byte();
                if ($urandom_range(0, 7) == 0) begin
                    keep = $urandom_range(1, table_q.size());
                    while (table_q.size() > keep) void'(table_q.pop_back());
                end
            end
        end else if (mode <= 7) begin
            // broken header fragments among noise
            repeat ($urandom_range(1, 3)) begin
                push_header($urandom_range(1, 6));
                repeat ($urandom_range(0, 3)) table_q.push_back(noise_byte());
            end
        end else if (mode == 8) begin
            repeat ($urandom_range(1, 16)) table_q.push_back(noise_byte());
        end else begin
            table_q.push_back(noise_byte());
        end
    endfunction

    // offer one byte and wait for the transfer; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_byte(b, last);
        n_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_table();
        int gap;
        for (int i = 0; i < table_q.size(); i++) begin
            gap = (sender_quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            send_byte(table_q[i], i == table_q.size() - 1, gap);
        end
        n_tables++;
    endtask

    // hold the sender back until every expected result has come
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // result side: random stalls, quiet stretches and one long hold-off
    initial begin
        int   hold_left;
        int   idle_left;
        logic sink_quiet;
        logic long_done;
        hold_left  = 0;
        idle_left  = 0;
        sink_quiet = 1'b0;
        long_done  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) sink_quiet = ($urandom_range(0, 2) == 0);
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!long_done && sb.n_checked >= 12) begin
                long_done       = 1'b1;
                hold_left       = LONG_HOLD;
                i_m_axis_tready <= 1'b0;
            end else if (idle_left > 0) begin
                i_m_axis_tready <= 1'b0;
                idle_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!sink_quiet && $urandom_range(0, 3) == 0) idle_left = pick_gap();
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result('{found:        o_m_axis_tuser,
                              sleep_type_a: o_m_axis_tdata[7:0],
                              sleep_type_b: o_m_axis_tdata[15:8]});
    end

    // stimulus
    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // long package length, byte const then word const, ignored last byte
        table_q = '{aml_s5_pkg::NAME_OP, aml_s5_pkg::CHAR_UNDER, aml_s5_pkg::CHAR_S,
                    aml_s5_pkg::CHAR_FIVE, aml_s5_pkg::CHAR_UNDER, aml_s5_pkg::PACKAGE_OP,
                    8'hC0, 8'hAA, 8'hBB, 8'hCC, 8'h02, aml_s5_pkg::BYTE_CONST, 8'h00,
                    aml_s5_pkg::WORD_CONST, 8'hFF, aml_s5_pkg::NAME_OP};
        send_table();
        // name opcode restarting a match, element count too small, failed search
        table_q = '{aml_s5_pkg::NAME_OP, aml_s5_pkg::NAME_OP, aml_s5_pkg::CHAR_UNDER,
                    aml_s5_pkg::CHAR_S, aml_s5_pkg::CHAR_FIVE, aml_s5_pkg::CHAR_UNDER,
                    aml_s5_pkg::PACKAGE_OP, 8'h00, 8'h01, aml_s5_pkg::WORD_CONST};
        send_table();

        // random tables
        while (n_bytes < TARGET_BYTES) begin
            sender_quiet = (n_tables >= 10 && n_tables < 20) ||
                           (n_tables >= 50 && n_tables < 60);
            if (n_tables == 30) wait_drained();
            build_table();
            send_table();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d tables in %0d byte transfers", n_tables, n_bytes);
        $display("%0d results checked, %0d with a decoded s5 package",
                 sb.n_checked, sb.n_found);
        if (sb.n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
